// File: rtl/twess_pkg.sv
package twess_pkg;

  // event kinds carried in s_tuser
  localparam logic [2:0] OP_MOVE    = 3'd0;
  localparam logic [2:0] OP_STOP    = 3'd1;
  localparam logic [2:0] OP_LTICK   = 3'd2;
  localparam logic [2:0] OP_RTICK   = 3'd3;
  localparam logic [2:0] OP_SYNC    = 3'd4;
  localparam logic [2:0] OP_RESTART = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_SYNC_ENABLE   = 3'd0;
  localparam logic [2:0] REG_PWM_UPPER     = 3'd1;
  localparam logic [2:0] REG_PWM_LOWER     = 3'd2;
  localparam logic [2:0] REG_DEADBAND      = 3'd3;
  localparam logic [2:0] REG_GAIN          = 3'd4;
  localparam logic [2:0] REG_START_PWM     = 3'd5;
  localparam logic [2:0] REG_BRAKE_PATTERN = 3'd6;

  // register reset values
  localparam logic [7:0] PWM_UPPER_RESET = 8'hff;
  localparam logic [7:0] START_PWM_RESET = 8'd128;
  localparam logic [7:0] GAIN_RESET      = 8'd1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // result word, highest bits first in the packed tdata
  typedef struct packed {
    logic [15:0] right_count;
    logic [15:0] left_count;
    logic        done_res;
    logic        moving;
    logic [7:0]  pwm_right;
    logic [7:0]  pwm_left;
    logic [3:0]  bridge_dir;
  } result_t;

endpackage

// File: rtl/two_wheel_encoder_step_and_sync.sv
// Two-wheel drive controller. Each input word is one event (move, stop, left
// encoder tick, right encoder tick, sync tick, restart; kind in s_tuser) and
// yields exactly one status word on the master side: bridge direction, both
// drive duties (zero while stopped), moving and done flags and both encoder
// counts. A move with a nonzero distance arms the counters; the tick that
// finds its count at or past the distance stops the drive and raises done.
// A sync tick (running, sync on) nudges both speeds by gain times the tick
// difference (wrapping modulo 256) outside the deadband, each only while
// short of its pwm limit, unclamped. A word is registered, evaluated against
// the state and written to the output register: one word per clock while
// m_tready is high; the only loop is the state update. Configuration is the
// user's to write via cfg_wr_en/cfg_index/cfg_data only while idle; the block does not enforce it.
module two_wheel_encoder_step_and_sync (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // event input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [twess_pkg::IN_DATA_W-1:0]  s_tdata,  // direction[3:0], distance[19:4],
                                                     // zero pad
  input  logic [2:0]  s_tuser,   // op[2:0]
  // status output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [twess_pkg::OUT_DATA_W-1:0] m_tdata   // bridge_dir[3:0], pwm_left[11:4],
                                                     // pwm_right[19:12], moving[20],
                                                     // done_res[21], left_count[37:22],
                                                     // right_count[53:38], zero pad
);

  // configuration registers
  logic       sync_enable;
  logic [7:0] pwm_upper;
  logic [7:0] pwm_lower;
  logic [7:0] deadband;
  logic [7:0] gain;
  logic [7:0] start_pwm;
  logic [3:0] brake_pattern;

  // drive state
  logic [7:0]  speed_left, speed_left_next;
  logic [7:0]  speed_right, speed_right_next;
  logic [15:0] ticks_left, ticks_left_next;
  logic [15:0] ticks_right, ticks_right_next;
  logic [15:0] limit, limit_next;
  logic        counting, counting_next;
  logic        running, running_next;
  logic        finished, finished_next;
  logic [3:0]  dir_now, dir_now_next;

  // input register
  logic        in_valid;
  logic [2:0]  in_op;
  logic [3:0]  in_dir;
  logic [15:0] in_dist;

  // output register
  logic                out_valid;
  twess_pkg::result_t  out_word;
  twess_pkg::result_t  res;

  logic advance;
  logic fire;

  // sync correction terms
  logic [15:0] diff;
  logic [15:0] prod;
  logic [7:0]  nudge;
  logic        above_band;
  logic        below_band;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(twess_pkg::OUT_DATA_W - $bits(twess_pkg::result_t)){1'b0}}, out_word};

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_enable   <= 1'b1;
      pwm_upper     <= twess_pkg::PWM_UPPER_RESET;
      pwm_lower     <= 8'd0;
      deadband      <= 8'd0;
      gain          <= twess_pkg::GAIN_RESET;
      start_pwm     <= twess_pkg::START_PWM_RESET;
      brake_pattern <= 4'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        twess_pkg::REG_SYNC_ENABLE:   sync_enable   <= cfg_data[0];
        twess_pkg::REG_PWM_UPPER:     pwm_upper     <= cfg_data;
        twess_pkg::REG_PWM_LOWER:     pwm_lower     <= cfg_data;
        twess_pkg::REG_DEADBAND:      deadband      <= cfg_data;
        twess_pkg::REG_GAIN:          gain          <= cfg_data;
        twess_pkg::REG_START_PWM:     start_pwm     <= cfg_data;
        twess_pkg::REG_BRAKE_PATTERN: brake_pattern <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_dir  <= s_tdata[3:0];
      in_dist <= s_tdata[19:4];
    end
  end

  // right minus left, signed view for the deadband test
  assign diff       = ticks_right - ticks_left;
  assign prod       = {8'd0, diff[7:0]} * {8'd0, gain};
  assign nudge      = prod[7:0];
  assign above_band = $signed({diff[15], diff}) > $signed({9'd0, deadband});
  assign below_band = $signed({diff[15], diff}) < -$signed({9'd0, deadband});

  // event evaluation
  always_comb begin
    speed_left_next  = speed_left;
    speed_right_next = speed_right;
    ticks_left_next  = ticks_left;
    ticks_right_next = ticks_right;
    limit_next       = limit;
    counting_next    = counting;
    running_next     = running;
    finished_next    = finished;
    dir_now_next     = dir_now;
    unique case (in_op)
      twess_pkg::OP_MOVE: begin
        finished_next    = 1'b0;
        dir_now_next     = in_dir;
        ticks_left_next  = 16'd0;
        ticks_right_next = 16'd0;
        limit_next       = in_dist;
        counting_next    = (in_dist != 16'd0);
        running_next     = 1'b1;
      end
      twess_pkg::OP_STOP: begin
        finished_next = 1'b0;
        counting_next = 1'b0;
        limit_next    = 16'd0;
        running_next  = 1'b0;
        dir_now_next  = brake_pattern;
      end
      twess_pkg::OP_LTICK: begin
        if (counting) begin
          ticks_left_next = ticks_left + 16'd1;
          if (ticks_left >= limit) begin
            running_next  = 1'b0;
            dir_now_next  = brake_pattern;
            finished_next = 1'b1;
          end
        end
      end
      twess_pkg::OP_RTICK: begin
        if (counting) begin
          ticks_right_next = ticks_right + 16'd1;
          if (ticks_right >= limit) begin
            running_next  = 1'b0;
            dir_now_next  = brake_pattern;
            finished_next = 1'b1;
          end
        end
      end
      twess_pkg::OP_SYNC: begin
        if (running && sync_enable) begin
          if (above_band) begin
            if (speed_left < pwm_upper)  speed_left_next  = speed_left + nudge;
            if (speed_right > pwm_lower) speed_right_next = speed_right - nudge;
          end else if (below_band) begin
            if (speed_left > pwm_lower)  speed_left_next  = speed_left + nudge;
            if (speed_right < pwm_upper) speed_right_next = speed_right - nudge;
          end
        end
      end
      twess_pkg::OP_RESTART: begin
        finished_next    = 1'b0;
        counting_next    = 1'b0;
        limit_next       = 16'd0;
        running_next     = 1'b0;
        dir_now_next     = brake_pattern;
        speed_left_next  = start_pwm;
        speed_right_next = start_pwm;
      end
      default: ;  // unused kinds only report status
    endcase
  end

  // status built from the updated state
  always_comb begin
    res.bridge_dir  = dir_now_next;
    res.pwm_left    = running_next ? speed_left_next : 8'd0;
    res.pwm_right   = running_next ? speed_right_next : 8'd0;
    res.moving      = running_next;
    res.done_res    = finished_next;
    res.left_count  = ticks_left_next;
    res.right_count = ticks_right_next;
  end

  // state and output register advance together
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_left  <= twess_pkg::START_PWM_RESET;
      speed_right <= twess_pkg::START_PWM_RESET;
      ticks_left  <= 16'd0;
      ticks_right <= 16'd0;
      limit       <= 16'd0;
      counting    <= 1'b0;
      running     <= 1'b0;
      finished    <= 1'b0;
      dir_now     <= 4'd0;
      out_valid   <= 1'b0;
    end else begin
      if (fire) begin
        speed_left  <= speed_left_next;
        speed_right <= speed_right_next;
        ticks_left  <= ticks_left_next;
        ticks_right <= ticks_right_next;
        limit       <= limit_next;
        counting    <= counting_next;
        running     <= running_next;
        finished    <= finished_next;
        dir_now     <= dir_now_next;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word <= res;
    end
  end

endmodule

// File: rtl/twess_checker.sv
module twess_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [twess_pkg::OUT_DATA_W-1:0] m_tdata
);

  // no word is shown in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // duties are zero whenever the drive is stopped
  a_idle_duty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[20] |-> m_tdata[19:4] == 16'd0)
    else $error("nonzero duty while stopped");

  // done only ever reported with the drive stopped
  a_done_stopped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[21] |-> !m_tdata[20])
    else $error("done flagged while moving");

endmodule

bind two_wheel_encoder_step_and_sync twess_checker u_twess_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

class drive_scoreboard;
  // register copy
  bit         sync_en;
  logic [7:0] pwm_hi, pwm_lo, dband, gain, start_pwm;
  logic [3:0] brake;
  // drive state
  logic [7:0]  spd_l, spd_r;
  logic [15:0] cnt_l, cnt_r, lim;
  bit          armed, run, fin;
  logic [3:0]  dir_now;
  twess_pkg::result_t status_q[$];
  int          errors;

  function new();
    sync_en   = 1'b1;
    pwm_hi    = twess_pkg::PWM_UPPER_RESET;
    pwm_lo    = 8'h00;
    dband     = 8'h00;
    gain      = twess_pkg::GAIN_RESET;
    start_pwm = twess_pkg::START_PWM_RESET;
    brake     = 4'h0;
    spd_l     = twess_pkg::START_PWM_RESET;
    spd_r     = twess_pkg::START_PWM_RESET;
    cnt_l     = '0;
    cnt_r     = '0;
    lim       = '0;
    armed     = 1'b0;
    run       = 1'b0;
    fin       = 1'b0;
    dir_now   = 4'h0;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [7:0] val);
    case (idx)
      twess_pkg::REG_SYNC_ENABLE:   sync_en = val[0];
      twess_pkg::REG_PWM_UPPER:     pwm_hi = val;
      twess_pkg::REG_PWM_LOWER:     pwm_lo = val;
      twess_pkg::REG_DEADBAND:      dband = val;
      twess_pkg::REG_GAIN:          gain = val;
      twess_pkg::REG_START_PWM:     start_pwm = val;
      twess_pkg::REG_BRAKE_PATTERN: brake = val[3:0];
      default: ;
    endcase
  endfunction

  // armed tick: the count before the tick is compared with the limit
  function logic [15:0] count_tick(logic [15:0] cnt);
    if (!armed) return cnt;
    if (cnt >= lim) begin
      run     = 1'b0;
      dir_now = brake;
      fin     = 1'b1;
    end
    return cnt + 16'd1;
  endfunction

  function void note_event(logic [2:0] op, logic [3:0] dir, logic [15:0] dist_ticks);
    logic [15:0] du;
    logic [23:0] prod;
    logic [7:0]  corr;
    int          diff;
    twess_pkg::result_t st;
    case (op)
      twess_pkg::OP_MOVE: begin
        fin     = 1'b0;
        dir_now = dir;
        cnt_l   = '0;
        cnt_r   = '0;
        armed   = (dist_ticks != 16'd0);
        lim     = dist_ticks;
        run     = 1'b1;
      end
      twess_pkg::OP_STOP, twess_pkg::OP_RESTART: begin
        fin     = 1'b0;
        armed   = 1'b0;
        lim     = '0;
        run     = 1'b0;
        dir_now = brake;
        if (op == twess_pkg::OP_RESTART) begin
          spd_l = start_pwm;
          spd_r = start_pwm;
        end
      end
      twess_pkg::OP_LTICK: cnt_l = count_tick(cnt_l);
      twess_pkg::OP_RTICK: cnt_r = count_tick(cnt_r);
      twess_pkg::OP_SYNC: begin
        if (run && sync_en) begin
          du   = cnt_r - cnt_l;
          diff = int'($signed(du));
          prod = {8'd0, du} * {16'd0, gain};
          corr = prod[7:0];
          if (diff > int'(dband)) begin
            if (spd_l < pwm_hi) spd_l = spd_l + corr;
            if (spd_r > pwm_lo) spd_r = spd_r - corr;
          end else if (diff < -int'(dband)) begin
            if (spd_l > pwm_lo) spd_l = spd_l + corr;
            if (spd_r < pwm_hi) spd_r = spd_r - corr;
          end
        end
      end
      default: ;
    endcase
    st.bridge_dir  = dir_now;
    st.pwm_left    = run ? spd_l : 8'h00;
    st.pwm_right   = run ? spd_r : 8'h00;
    st.moving      = run;
    st.done_res    = fin;
    st.left_count  = cnt_l;
    st.right_count = cnt_r;
    status_q.push_back(st);
  endfunction

  function void cmp(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  function void check_result(logic [55:0] word);
    twess_pkg::result_t want, got;
    got = word[53:0];
    if (status_q.size() == 0) begin
      errors++;
      $display("%0t unexpected status word: expected none, actual %h", $time, word);
      return;
    end
    want = status_q.pop_front();
    cmp("bridge_dir", 16'(want.bridge_dir), 16'(got.bridge_dir));
    cmp("pwm_left", 16'(want.pwm_left), 16'(got.pwm_left));
    cmp("pwm_right", 16'(want.pwm_right), 16'(got.pwm_right));
    cmp("moving", 16'(want.moving), 16'(got.moving));
    cmp("done_res", 16'(want.done_res), 16'(got.done_res));
    cmp("left_count", want.left_count, got.left_count);
    cmp("right_count", want.right_count, got.right_count);
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module testbench;

  // spare event kinds: the block only reports its status on these
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 195;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // direction[3:0], distance[19:4], zero pad
  logic [2:0]  s_tuser;   // op[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // bridge_dir, pwm_left, pwm_right, moving, done_res,
                          // left_count, right_count, zero pad

  drive_scoreboard sb = new();

  // random gaps on both sides, switched off for the closing phase
  bit gaps_on  = 1'b1;
  // asks the receiver for one long hold-off
  bit hold_req = 1'b0;
  int unsigned cycles = 0;

  two_wheel_encoder_step_and_sync DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // both monitors sample the values seen at the edge; the output is checked
  // before the input is noted since a result never leaves in its own cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (s_tvalid && s_tready) sb.note_event(s_tuser, s_tdata[3:0], s_tdata[19:4]);
    end
  end

  // receiver: short random stalls plus one long hold-off on request
  initial begin
    int unsigned stall;
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5);
        m_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one event word and hold it until the block takes it
  task automatic send_event(input logic [2:0] op, input logic [3:0] dir,
                            input logic [15:0] dist_ticks);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'h0, dist_ticks, dir};
    do @(posedge clk); while (!s_tready);
  endtask

  // stop offering and wait until every status word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic sync_en, input logic [7:0] hi, input logic [7:0] lo,
                              input logic [7:0] db, input logic [7:0] gn,
                              input logic [7:0] sp, input logic [3:0] bk);
    write_reg(twess_pkg::REG_SYNC_ENABLE, {7'd0, sync_en});
    write_reg(twess_pkg::REG_PWM_UPPER, hi);
    write_reg(twess_pkg::REG_PWM_LOWER, lo);
    write_reg(twess_pkg::REG_DEADBAND, db);
    write_reg(twess_pkg::REG_GAIN, gn);
    write_reg(twess_pkg::REG_START_PWM, sp);
    write_reg(twess_pkg::REG_BRAKE_PATTERN, {4'h0, bk});
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned ph, sent, len, r;
    logic [2:0]  op;
    logic [15:0] dist_ticks;

    rst       <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset register values
    send_event(OP_SPARE6, 4'hf, 16'hffff);  // status straight after reset
    send_event(OP_SPARE7, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_SYNC, 4'h3, 16'h0000);    // sync while stopped
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);   // tick while disarmed
    send_event(twess_pkg::OP_MOVE, 4'ha, 16'h0000);    // unlimited move, counters off
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_SYNC, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_MOVE, 4'h5, 16'h0002);    // limited move
    send_event(twess_pkg::OP_RTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_RTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_SYNC, 4'h0, 16'h0000);    // right ahead: positive branch
    send_event(twess_pkg::OP_RTICK, 4'h0, 16'h0000);   // reaches the distance
    send_event(twess_pkg::OP_RTICK, 4'h0, 16'h0000);   // done raised again after the stop
    send_event(twess_pkg::OP_SYNC, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_STOP, 4'h9, 16'h1234);    // clears done
    send_event(twess_pkg::OP_MOVE, 4'hf, 16'hffff);
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_SYNC, 4'h0, 16'h0000);    // left ahead: negative branch, wraps
    send_event(twess_pkg::OP_RESTART, 4'h6, 16'h8000); // speeds back to start value
    send_event(twess_pkg::OP_MOVE, 4'h0, 16'h0001);
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_LTICK, 4'h0, 16'h0000);
    send_event(twess_pkg::OP_RESTART, 4'h0, 16'h0000);
    drain();

    // random phases, each under its own register setting
    for (ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1: program_regs(1'b1, 8'hff, 8'h00, 8'h00, 8'h01, 8'h80, 4'h0);
        2: program_regs(1'b0, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 4'hf);
        3: program_regs(1'b1, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 4'h5);
        4: program_regs(1'b1, 8'hff, 8'h00, 8'hff, 8'h01, 8'hff, 4'ha);
        5: program_regs(1'b1, 8'h00, 8'hff, 8'h00, 8'h03, 8'h40, 4'h3);
        default: program_regs($urandom_range(0, 3) != 0, 8'($urandom_range(128, 255)),
                              8'($urandom_range(0, 127)), 8'($urandom_range(0, 4)),
                              8'($urandom), 8'($urandom), 4'($urandom));
      endcase
      // closing phase runs with neither side idling
      if (ph == PHASES) gaps_on = 1'b0;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        // long receiver hold-off in phase 4, when a run starts at word 40
        if (ph == 4 && sent == 40) hold_req = 1'b1;
        r = $urandom_range(0, 9);
        if (r == 0) dist_ticks = 16'h0000;
        else if (r == 1) dist_ticks = 16'($urandom);
        else dist_ticks = 16'($urandom_range(1, 12));
        send_event(twess_pkg::OP_MOVE, 4'($urandom), dist_ticks);
        sent++;
        // a run: ticks and syncs with some stops, restarts and noise
        len = $urandom_range(2, 24);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 35) op = twess_pkg::OP_LTICK;
          else if (r < 70) op = twess_pkg::OP_RTICK;
          else if (r < 88) op = twess_pkg::OP_SYNC;
          else if (r < 92) op = twess_pkg::OP_STOP;
          else if (r < 96) op = twess_pkg::OP_RESTART;
          else if (r < 98) op = twess_pkg::OP_MOVE;
          else op = ($urandom_range(0, 1) != 0) ? OP_SPARE6 : OP_SPARE7;
          send_event(op, 4'($urandom), 16'($urandom));
          sent++;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/twess_pkg.sv
rtl/two_wheel_encoder_step_and_sync.sv
rtl/twess_checker.sv
test/testbench.sv
